[rtl/spg_pkg.sv]
// ----------------------------------------------------------------------------
// spg_pkg
// Shared widths, controller states and the command/status bundles that join
// the sequencer to the datapath of the swap permutation generator.
// ----------------------------------------------------------------------------
package spg_pkg;

    // Largest number of elements that can be permuted (2 .. 8)
    localparam int MAX_ELEMENTS = 8;

    // Width of one packed index in the result word
    localparam int IDX_W   = 3;
    // Width of the element count register
    localparam int CNT_W   = 4;
    // Width of the packed result word
    localparam int ORDER_W = 24;
    // Width of a position / loop index inside the stack
    localparam int LVL_W   = $clog2(MAX_ELEMENTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNW_RD,
        ST_UNW_SWAP,
        ST_ADV_RD,
        ST_ADV_SWAP,
        ST_EMIT,
        ST_EXHAUST
    } state_t;

    typedef struct packed {
        logic load_start;   // identity order, fresh loop indices
        logic set_top;      // level pointer to the deepest branching level
        logic dec_lvl;      // step one level up
        logic rd_lvl;       // hold the entry at the current level
        logic swap_sel;     // swap current level with its loop index position
        logic inc_lli;      // advance the loop index, reset deeper levels
        logic emit_perm;    // load the output register with the permutation
        logic emit_exh;     // load the output register with exhaustion
    } cmd_t;

    typedef struct packed {
        logic started;
        logic done;
        logic n_one;
        logic can_inc;
        logic lvl_zero;
        logic out_free;
    } status_t;

endpackage

[rtl/spg_ctrl.sv]
// ----------------------------------------------------------------------------
// spg_ctrl
// Sequencer: accepts one request, walks the backtracking stack one level at
// a time and hands the result to the output register.
// ----------------------------------------------------------------------------
module spg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_restart,
    output logic             in_ready,
    input  spg_pkg::status_t status,
    output spg_pkg::cmd_t    cmd
);

    spg_pkg::state_t state_reg;
    spg_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            spg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_restart || !status.started)
                    begin
                        cmd.load_start = 1'b1;
                        state_next     = spg_pkg::ST_EMIT;
                    end
                    else if (status.done || status.n_one)
                    begin
                        state_next = spg_pkg::ST_EXHAUST;
                    end
                    else
                    begin
                        cmd.set_top = 1'b1;
                        state_next  = spg_pkg::ST_UNW_RD;
                    end
                end
            end
            spg_pkg::ST_UNW_RD:
            begin
                cmd.rd_lvl = 1'b1;
                state_next = spg_pkg::ST_UNW_SWAP;
            end
            spg_pkg::ST_UNW_SWAP:
            begin
                // undo the swap of this level, then branch or climb
                cmd.swap_sel = 1'b1;
                if (status.can_inc)
                begin
                    state_next = spg_pkg::ST_ADV_RD;
                end
                else if (status.lvl_zero)
                begin
                    state_next = spg_pkg::ST_EXHAUST;
                end
                else
                begin
                    cmd.dec_lvl = 1'b1;
                    state_next  = spg_pkg::ST_UNW_RD;
                end
            end
            spg_pkg::ST_ADV_RD:
            begin
                cmd.inc_lli = 1'b1;
                cmd.rd_lvl  = 1'b1;
                state_next  = spg_pkg::ST_ADV_SWAP;
            end
            spg_pkg::ST_ADV_SWAP:
            begin
                cmd.swap_sel = 1'b1;
                state_next   = spg_pkg::ST_EMIT;
            end
            spg_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_perm = 1'b1;
                    state_next    = spg_pkg::ST_IDLE;
                end
            end
            spg_pkg::ST_EXHAUST:
            begin
                if (status.out_free)
                begin
                    cmd.emit_exh = 1'b1;
                    state_next   = spg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/spg_datapath.sv]
// ----------------------------------------------------------------------------
// spg_datapath
// Working order, per-level loop indices, sequence flags, element count and
// the output register. One entry of the working order is read per cycle.
// ----------------------------------------------------------------------------
module spg_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [spg_pkg::CNT_W-1:0]     cfg_wdata,
    input  spg_pkg::cmd_t                 cmd,
    output spg_pkg::status_t              status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [spg_pkg::ORDER_W-1:0]   out_order,
    output logic                          out_final,
    output logic                          out_exh
);

    logic [spg_pkg::CNT_W-1:0]   count_reg;
    logic [spg_pkg::IDX_W-1:0]   wo_reg  [spg_pkg::MAX_ELEMENTS];
    logic [spg_pkg::LVL_W-1:0]   lli_reg [spg_pkg::MAX_ELEMENTS];
    logic [spg_pkg::LVL_W-1:0]   lvl_reg;
    logic [spg_pkg::IDX_W-1:0]   tmp_reg;
    logic                        started_reg;
    logic                        done_reg;
    logic                        out_valid_reg;
    logic [spg_pkg::ORDER_W-1:0] out_order_reg;
    logic                        out_final_reg;
    logic                        out_exh_reg;

    logic [spg_pkg::CNT_W-1:0]   n_eff;
    logic [spg_pkg::LVL_W-1:0]   sel;
    logic [spg_pkg::LVL_W-1:0]   rd_addr;
    logic [spg_pkg::IDX_W-1:0]   rd_data;
    logic                        last;
    logic [spg_pkg::ORDER_W-1:0] order_pack;

    // saturate the count into 1 .. MAX_ELEMENTS
    always_comb
    begin
        if (count_reg == '0)
        begin
            n_eff = spg_pkg::CNT_W'(1);
        end
        else if (count_reg > spg_pkg::CNT_W'(spg_pkg::MAX_ELEMENTS))
        begin
            n_eff = spg_pkg::CNT_W'(spg_pkg::MAX_ELEMENTS);
        end
        else
        begin
            n_eff = count_reg;
        end
    end

    assign sel     = lli_reg[lvl_reg];
    assign rd_addr = cmd.swap_sel ? sel : lvl_reg;
    assign rd_data = wo_reg[rd_addr];

    always_comb
    begin
        last       = 1'b1;
        order_pack = '0;
        for (int k = 0; k < spg_pkg::MAX_ELEMENTS; k++)
        begin
            if ((spg_pkg::CNT_W'(k + 1) < n_eff) &&
                (spg_pkg::CNT_W'(lli_reg[k]) != (n_eff - spg_pkg::CNT_W'(1))))
            begin
                last = 1'b0;
            end
            if (spg_pkg::CNT_W'(k) < n_eff)
            begin
                order_pack[spg_pkg::IDX_W*k +: spg_pkg::IDX_W] = wo_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= spg_pkg::CNT_W'(4);
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    // working order and loop index stack
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < spg_pkg::MAX_ELEMENTS; k++)
            begin
                wo_reg[k]  <= spg_pkg::IDX_W'(k);
                lli_reg[k] <= '0;
            end
        end
        else if (cfg_we || cmd.emit_exh)
        begin
            for (int k = 0; k < spg_pkg::MAX_ELEMENTS; k++)
            begin
                wo_reg[k]  <= spg_pkg::IDX_W'(k);
                lli_reg[k] <= '0;
            end
        end
        else if (cmd.load_start)
        begin
            for (int k = 0; k < spg_pkg::MAX_ELEMENTS; k++)
            begin
                wo_reg[k]  <= spg_pkg::IDX_W'(k);
                lli_reg[k] <= (spg_pkg::CNT_W'(k + 1) < n_eff) ? spg_pkg::LVL_W'(k) : '0;
            end
        end
        else
        begin
            for (int k = 0; k < spg_pkg::MAX_ELEMENTS; k++)
            begin
                if (cmd.swap_sel)
                begin
                    if (spg_pkg::LVL_W'(k) == sel)
                    begin
                        wo_reg[k] <= tmp_reg;
                    end
                    else if (spg_pkg::LVL_W'(k) == lvl_reg)
                    begin
                        wo_reg[k] <= rd_data;
                    end
                end
                if (cmd.inc_lli)
                begin
                    if (spg_pkg::LVL_W'(k) == lvl_reg)
                    begin
                        lli_reg[k] <= sel + spg_pkg::LVL_W'(1);
                    end
                    else if ((spg_pkg::LVL_W'(k) > lvl_reg) &&
                             (spg_pkg::CNT_W'(k + 1) < n_eff))
                    begin
                        lli_reg[k] <= spg_pkg::LVL_W'(k);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_lvl)
        begin
            tmp_reg <= rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg <= '0;
        end
        else if (cmd.set_top)
        begin
            lvl_reg <= spg_pkg::LVL_W'(n_eff - spg_pkg::CNT_W'(2));
        end
        else if (cmd.dec_lvl)
        begin
            lvl_reg <= lvl_reg - spg_pkg::LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (cmd.load_start)
        begin
            started_reg <= 1'b1;
            done_reg    <= 1'b0;
        end
        else if (cmd.emit_exh || (cmd.emit_perm && last))
        begin
            done_reg <= 1'b1;
        end
    end

    // output register: a waiting result does not block the next request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_perm || cmd.emit_exh)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_perm)
        begin
            out_order_reg <= order_pack;
            out_final_reg <= last;
            out_exh_reg   <= 1'b0;
        end
        else if (cmd.emit_exh)
        begin
            out_order_reg <= '0;
            out_final_reg <= 1'b0;
            out_exh_reg   <= 1'b1;
        end
    end

    assign status.started  = started_reg;
    assign status.done     = done_reg;
    assign status.n_one    = (n_eff == spg_pkg::CNT_W'(1));
    assign status.can_inc  = ((spg_pkg::CNT_W'(sel) + spg_pkg::CNT_W'(1)) < n_eff);
    assign status.lvl_zero = (lvl_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_order = out_order_reg;
    assign out_final = out_final_reg;
    assign out_exh   = out_exh_reg;

endmodule

[rtl/swap_permutation_generator.sv]
// ----------------------------------------------------------------------------
// swap_permutation_generator
// Backtracking swap-and-restore permutation generator: one ordering of the
// first element_count indices per request, as packed 3-bit indices.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata[0] restart
//  m_axis    out        tdata[23:0] order_indices, tlast final_one,
//                       tuser exhausted
//  cfg       in         cfg_wdata[3:0] element_count
//
//  A restart (or the first request) passes from the transfer through EMIT to
//  the result. A next request unwinds L stack levels (1 .. element_count-1),
//  each in a read state and a swap state, as the walk swaps through one read
//  port of the working order; then ADV_RD, ADV_SWAP and EMIT give the result.
//  Exhaustion goes straight to EXHAUST once the sequence is done, and follows
//  the walk through all element_count-1 levels when it runs out of levels.
//  Reset restores the identity order and element_count 4. A stalled result
//  holds in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module swap_permutation_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,    // element_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [0] restart, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // [23:0] order_indices
    output logic        m_tlast,      // final_one
    output logic        m_tuser       // exhausted
);

    spg_pkg::cmd_t    cmd;
    spg_pkg::status_t status;

    spg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_restart (s_tdata[0]),
        .in_ready   (s_tready),
        .status     (status),
        .cmd        (cmd)
    );

    spg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_order (m_tdata),
        .out_final (m_tlast),
        .out_exh   (m_tuser)
    );

`ifndef SYNTHESIS
    // one request at a time: no transfer in the cycle after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one still in work");

    // an exhausted result carries no order and no final flag
    a_exh_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == '0) && !m_tlast)
        else $error("exhausted result with payload");

    // at most one of start and the two output loads per cycle
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_start, cmd.emit_perm, cmd.emit_exh}))
        else $error("conflicting datapath commands");
`endif

endmodule
